// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: entry layout,
// operation codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 8;
	localparam int COUNT_W = 5;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [VALUE_W-1:0] value;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/spq_mem.sv -----
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire spq_pkg::entry_t wr_data,
	input  wire logic [AW-1:0]   rd_addr,
	output spq_pkg::entry_t      rd_data
);

	spq_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/spq_seq.sv -----
// ----------------------------------------------------------------------------
// spq_seq
// Queue sequencer: keeps head and count of a circular sorted list and walks
// the tail back one entry per step through a single compare unit on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_seq #(
	parameter int CAPACITY = 16,
	parameter int AW       = 4,
	parameter int CW       = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          action,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] item_value,
	input  wire logic [spq_pkg::PRIO_W-1:0]    priority_req,
	output logic                               done,
	output logic signed [spq_pkg::VALUE_W-1:0] head_value,
	output logic [1:0]                         status,
	output logic [spq_pkg::COUNT_W-1:0]        entry_count,
	output logic                               mem_wr_en,
	output logic [AW-1:0]                      mem_wr_addr,
	output spq_pkg::entry_t                    mem_wr_data,
	output logic [AW-1:0]                      mem_rd_addr,
	input  wire spq_pkg::entry_t               mem_rd_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_DQ   = 2'd3;

	localparam logic [AW:0]   CAP_W   = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	logic [1:0]                  state_q;
	logic [AW-1:0]               head_q;
	logic [CW-1:0]               count_q;
	logic [AW-1:0]               pos_q;
	logic [spq_pkg::VALUE_W-1:0] val_q;
	logic [spq_pkg::PRIO_W-1:0]  prio_q;
	logic                        done_q;
	logic [spq_pkg::VALUE_W-1:0] res_value_q;
	logic [1:0]                  res_status_q;
	logic [spq_pkg::COUNT_W-1:0] res_count_q;

	logic [AW-1:0] phys_pos;
	logic [AW-1:0] phys_prev;
	logic [AW-1:0] head_next;
	logic [AW-1:0] pos_prev;
	logic          shift_up;

	// Map a logical list place onto the ring.
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
			input logic [AW-1:0] ofs);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= CAP_W) begin
			sum = sum - CAP_W;
		end
		return sum[AW-1:0];
	endfunction

	assign pos_prev  = pos_q - AW'(1);
	assign phys_pos  = ring_add(head_q, pos_q);
	assign phys_prev = ring_add(head_q, pos_prev);
	assign head_next = ring_add(head_q, AW'(1));
	// Move the older entry up while its priority is strictly larger.
	assign shift_up  = (mem_rd_data.prio > prio_q);

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign head_value  = res_value_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = phys_pos;
		mem_wr_data = '{prio: prio_q, value: val_q};
		mem_rd_addr = head_q;
		case (state_q)
			ST_RD: begin
				mem_rd_addr = phys_prev;
				mem_wr_en   = (pos_q == '0);
			end
			ST_CMP: begin
				mem_wr_en = 1'b1;
				if (shift_up) begin
					mem_wr_data = mem_rd_data;
				end
			end
			default: begin
				mem_rd_addr = head_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (action == spq_pkg::ACT_ENQ) begin
							if (count_q == CAP_CNT) begin
								done_q <= 1'b1;
							end else begin
								state_q <= ST_RD;
							end
						end else begin
							if (count_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= ST_DQ;
							end
						end
					end
				end
				ST_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + CW'(1);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (shift_up) begin
						state_q <= ST_RD;
					end else begin
						count_q <= count_q + CW'(1);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DQ: begin
					head_q  <= head_next;
					count_q <= count_q - CW'(1);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload and result words, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				val_q       <= item_value;
				prio_q      <= priority_req;
				pos_q       <= count_q[AW-1:0];
				res_value_q <= '0;
				res_count_q <= spq_pkg::COUNT_W'(count_q);
				if (action == spq_pkg::ACT_ENQ) begin
					res_status_q <= spq_pkg::STATUS_FULL;
				end else begin
					res_status_q <= spq_pkg::STATUS_EMPTY;
				end
			end
			ST_RD: begin
				res_value_q  <= '0;
				res_status_q <= spq_pkg::STATUS_OK;
				res_count_q  <= spq_pkg::COUNT_W'(count_q + CW'(1));
			end
			ST_CMP: begin
				if (shift_up) begin
					pos_q <= pos_prev;
				end
				res_value_q  <= '0;
				res_status_q <= spq_pkg::STATUS_OK;
				res_count_q  <= spq_pkg::COUNT_W'(count_q + CW'(1));
			end
			ST_DQ: begin
				res_value_q  <= mem_rd_data.value;
				res_status_q <= spq_pkg::STATUS_OK;
				res_count_q  <= spq_pkg::COUNT_W'(count_q - CW'(1));
			end
			default: begin
				res_status_q <= spq_pkg::STATUS_OK;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted ring of entries in one memory.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// head_value, status and entry_count for exactly one cycle with done high,
// and the receiver cannot stall it. A rejected word (dequeue on empty,
// enqueue on full) keeps busy low and its result follows in the next cycle. A
// dequeue keeps busy high while the head moves on by one entry. An enqueue
// keeps busy high while older entries move up one place per step; each step
// of the insertion walk reads one entry from the memory port and compares its
// priority in the next cycle; start may be raised again as done pulses.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                action,
	input  wire logic signed [spq_pkg::VALUE_W-1:0]  item_value,
	input  wire logic [spq_pkg::PRIO_W-1:0]          priority_req,
	output logic                                     done,
	output logic signed [spq_pkg::VALUE_W-1:0]       head_value,
	output logic [1:0]                               status,
	output logic [spq_pkg::COUNT_W-1:0]              entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic            mem_wr_en;
	logic [AW-1:0]   mem_wr_addr;
	spq_pkg::entry_t mem_wr_data;
	logic [AW-1:0]   mem_rd_addr;
	spq_pkg::entry_t mem_rd_data;

	spq_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.item_value   (item_value),
		.priority_req (priority_req),
		.done         (done),
		.head_value   (head_value),
		.status       (status),
		.entry_count  (entry_count),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data)
	);

	spq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

`default_nettype wire
